/* rtl/ttcb_pkg.sv */
// shared constants, command type and helper functions for the terminal cell buffer
package ttcb_pkg;

	// grid geometry
	localparam int MAX_COLUMNS = 64;
	localparam int MAX_ROWS    = 32;

	localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int NCOL_W = $clog2(MAX_COLUMNS + 1);
	localparam int NROW_W = $clog2(MAX_ROWS + 1);
	localparam int CUR_COL_W = NCOL_W;

	// field widths
	localparam int ACTION_W   = 2;
	localparam int BYTE_W     = 8;
	localparam int RROW_W     = 5;
	localparam int RCOL_W     = 6;
	localparam int OUT_ROW_W  = 5;
	localparam int OUT_COL_W  = 6;
	localparam int CFG_COL_W  = 7;
	localparam int CFG_ROW_W  = 6;
	localparam int CFG_DATA_W = 7;
	localparam int CFG_IDX_W  = 1;

	// register indexes and reset values
	localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 1'd1;
	localparam logic [CFG_COL_W-1:0] COLS_RESET  = 7'd40;
	localparam logic [CFG_ROW_W-1:0] ROWS_RESET  = 6'd14;

	// actions
	localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

	// characters
	localparam logic [BYTE_W-1:0] BLANK  = 8'h20;
	localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_BS  = 8'h08;
	localparam logic [BYTE_W-1:0] CH_DEL = 8'h7F;
	localparam logic [BYTE_W-1:0] CH_TAB = 8'h09;

	localparam int TAB_STOP  = 4;
	localparam int TAB_CNT_W = $clog2(TAB_STOP + 1);
	localparam int TAB_LOW_W = $clog2(TAB_STOP);

	// classified operations
	localparam int OP_W = 3;
	localparam logic [OP_W-1:0] OP_PRINT = 3'd0;
	localparam logic [OP_W-1:0] OP_CR    = 3'd1;
	localparam logic [OP_W-1:0] OP_LF    = 3'd2;
	localparam logic [OP_W-1:0] OP_BS    = 3'd3;
	localparam logic [OP_W-1:0] OP_TAB   = 3'd4;
	localparam logic [OP_W-1:0] OP_NOP   = 3'd5;
	localparam logic [OP_W-1:0] OP_CLEAR = 3'd6;
	localparam logic [OP_W-1:0] OP_READ  = 3'd7;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [BYTE_W-1:0] ch;
		logic [RROW_W-1:0] rr;
		logic [RCOL_W-1:0] rc;
	} cmd_t;

	function automatic logic [NCOL_W-1:0] cols_eff(input logic [CFG_COL_W-1:0] c);
		logic [NCOL_W-1:0] n;
		if (c == '0) n = NCOL_W'(1);
		else if (int'(c) > MAX_COLUMNS) n = NCOL_W'(MAX_COLUMNS);
		else n = NCOL_W'(c);
		return n;
	endfunction

	function automatic logic [NROW_W-1:0] rows_eff(input logic [CFG_ROW_W-1:0] r);
		logic [NROW_W-1:0] n;
		if (r == '0) n = NROW_W'(1);
		else if (int'(r) > MAX_ROWS) n = NROW_W'(MAX_ROWS);
		else n = NROW_W'(r);
		return n;
	endfunction

endpackage

/* rtl/ttcb_front.sv */
// input side: accepts items and classifies them into commands for the queue
module ttcb_front (
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [ttcb_pkg::ACTION_W-1:0]       action,
	input  logic [ttcb_pkg::BYTE_W-1:0]         byte_in,
	input  logic [ttcb_pkg::RROW_W-1:0]         read_row,
	input  logic [ttcb_pkg::RCOL_W-1:0]         read_col,
	input  logic                                q_full,
	input  logic                                clearing,
	output logic                                push,
	output ttcb_pkg::cmd_t                      cmd
);

	logic [ttcb_pkg::OP_W-1:0] byte_op;

	assign in_ready = !q_full && !clearing;
	assign push     = in_valid && in_ready;

	always_comb begin
		case (byte_in)
			ttcb_pkg::CH_CR:                  byte_op = ttcb_pkg::OP_CR;
			ttcb_pkg::CH_LF:                  byte_op = ttcb_pkg::OP_LF;
			ttcb_pkg::CH_BS, ttcb_pkg::CH_DEL: byte_op = ttcb_pkg::OP_BS;
			ttcb_pkg::CH_TAB:                 byte_op = ttcb_pkg::OP_TAB;
			default: begin
				// remaining control bytes do nothing
				if (byte_in < ttcb_pkg::BLANK) byte_op = ttcb_pkg::OP_NOP;
				else byte_op = ttcb_pkg::OP_PRINT;
			end
		endcase
	end

	always_comb begin
		cmd.ch = byte_in;
		cmd.rr = read_row;
		cmd.rc = read_col;
		case (action)
			ttcb_pkg::ACT_PUT:   cmd.op = byte_op;
			ttcb_pkg::ACT_CLEAR: cmd.op = ttcb_pkg::OP_CLEAR;
			ttcb_pkg::ACT_READ:  cmd.op = ttcb_pkg::OP_READ;
			default:             cmd.op = ttcb_pkg::OP_NOP;
		endcase
	end

endmodule

/* rtl/ttcb_queue.sv */
// short command queue between the classifier and the screen engine
module ttcb_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ttcb_pkg::cmd_t cmd_in,
	output logic           full,
	input  logic           pop,
	output logic           q_valid,
	output ttcb_pkg::cmd_t head
);

	ttcb_pkg::cmd_t                entry_q [ttcb_pkg::QUEUE_DEPTH];
	logic [ttcb_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [ttcb_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [ttcb_pkg::QCNT_W-1:0]   count_q;

	assign full    = (count_q == ttcb_pkg::QCNT_W'(ttcb_pkg::QUEUE_DEPTH));
	assign q_valid = (count_q != '0);
	assign head    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= cmd_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				if (wr_ptr_q == ttcb_pkg::QPTR_W'(ttcb_pkg::QUEUE_DEPTH - 1)) wr_ptr_q <= '0;
				else wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				if (rd_ptr_q == ttcb_pkg::QPTR_W'(ttcb_pkg::QUEUE_DEPTH - 1)) rd_ptr_q <= '0;
				else rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

/* rtl/ttcb_back.sv */
// screen engine: cursor, cell store, scroll and clear sequencing, result register
module ttcb_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [ttcb_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ttcb_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 q_valid,
	input  ttcb_pkg::cmd_t                       q_cmd,
	output logic                                 q_pop,
	output logic                                 clearing,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [ttcb_pkg::BYTE_W-1:0]          cell_char,
	output logic [ttcb_pkg::OUT_ROW_W-1:0]       cursor_row,
	output logic [ttcb_pkg::OUT_COL_W-1:0]       cursor_col
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_TAB    = 3'd1;
	localparam logic [2:0] ST_SCROLL = 3'd2;
	localparam logic [2:0] ST_CLEAR  = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;

	typedef logic [ttcb_pkg::MAX_COLUMNS-1:0][ttcb_pkg::BYTE_W-1:0] row_t;

	row_t                                cells_q [ttcb_pkg::MAX_ROWS];
	row_t                                rd_data_q;

	logic [ttcb_pkg::CFG_COL_W-1:0]      cols_q;
	logic [ttcb_pkg::CFG_ROW_W-1:0]      rows_q;
	logic [2:0]                          state_q, state_d;
	logic [ttcb_pkg::ROW_W-1:0]          row_q, row_d;
	logic [ttcb_pkg::CUR_COL_W-1:0]      col_q, col_d;
	logic [ttcb_pkg::TAB_CNT_W-1:0]      tab_cnt_q, tab_d;
	logic [ttcb_pkg::ROW_W-1:0]          clr_row_q, clr_row_d;
	logic                                clr_op_q, clr_op_d;
	logic [ttcb_pkg::NROW_W-1:0]         sc_row_q, sc_row_d;
	logic                                pend_q, pend_d;
	logic [ttcb_pkg::ROW_W-1:0]          pend_row_q, pend_row_d;
	logic                                rd_hit_q, rd_hit_d;
	logic [ttcb_pkg::COL_W-1:0]          rd_col_q, rd_col_d;
	logic                                out_valid_q;
	logic [ttcb_pkg::BYTE_W-1:0]         out_cell_q;
	logic [ttcb_pkg::OUT_ROW_W-1:0]      out_row_q;
	logic [ttcb_pkg::OUT_COL_W-1:0]      out_col_q;

	logic [ttcb_pkg::NCOL_W-1:0]         nc;
	logic [ttcb_pkg::NROW_W-1:0]         nr;
	logic [ttcb_pkg::ROW_W-1:0]          last_row;
	logic [ttcb_pkg::CUR_COL_W-1:0]      col_inc, col_dec, pr_col;
	logic [ttcb_pkg::NROW_W-1:0]         row_inc;
	logic [ttcb_pkg::ROW_W-1:0]          pr_row;
	logic                                wrap, lf_scroll, pr_scroll, row_in, cur_in, bs_in;
	logic [ttcb_pkg::MAX_COLUMNS-1:0]    use_mask, cur_onehot, dec_onehot;

	logic                                wr_en, rd_en;
	logic [ttcb_pkg::ROW_W-1:0]          wr_row, rd_row;
	logic [ttcb_pkg::MAX_COLUMNS-1:0]    wr_mask;
	row_t                                wr_data;

	assign nc       = ttcb_pkg::cols_eff(cols_q);
	assign nr       = ttcb_pkg::rows_eff(rows_q);
	assign last_row = ttcb_pkg::ROW_W'(nr - ttcb_pkg::NROW_W'(1));

	// cursor arithmetic shared by printable bytes, tab spaces and line feed
	assign col_inc   = col_q + 1'b1;
	assign col_dec   = col_q - 1'b1;
	assign row_inc   = ttcb_pkg::NROW_W'(row_q) + 1'b1;
	assign wrap      = (col_inc >= nc);
	assign lf_scroll = (row_inc >= nr);
	assign pr_scroll = wrap && lf_scroll;
	assign pr_col    = wrap ? '0 : col_inc;
	assign pr_row    = !wrap ? row_q : (lf_scroll ? last_row : ttcb_pkg::ROW_W'(row_inc));
	assign row_in    = (ttcb_pkg::NROW_W'(row_q) < nr);
	assign cur_in    = row_in && (col_q < nc);
	assign bs_in     = row_in && (col_dec < nc);

	always_comb begin
		for (int c = 0; c < ttcb_pkg::MAX_COLUMNS; c++) begin
			use_mask[c]   = (ttcb_pkg::NCOL_W'(c) < nc);
			cur_onehot[c] = (col_q == ttcb_pkg::CUR_COL_W'(c));
			dec_onehot[c] = (col_dec == ttcb_pkg::CUR_COL_W'(c));
		end
	end

	always_comb begin
		state_d    = state_q;
		row_d      = row_q;
		col_d      = col_q;
		tab_d      = tab_cnt_q;
		clr_row_d  = clr_row_q;
		clr_op_d   = clr_op_q;
		sc_row_d   = sc_row_q;
		pend_d     = 1'b0;
		pend_row_d = pend_row_q;
		rd_hit_d   = rd_hit_q;
		rd_col_d   = rd_col_q;
		q_pop      = 1'b0;
		wr_en      = 1'b0;
		wr_row     = row_q;
		wr_mask    = cur_onehot;
		wr_data    = {ttcb_pkg::MAX_COLUMNS{ttcb_pkg::BLANK}};
		rd_en      = 1'b0;
		rd_row     = ttcb_pkg::ROW_W'(sc_row_q);

		case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_row  = clr_row_q;
				wr_mask = '1;
				if (clr_row_q == ttcb_pkg::ROW_W'(ttcb_pkg::MAX_ROWS - 1)) begin
					clr_row_d = '0;
					clr_op_d  = 1'b0;
					state_d   = clr_op_q ? ST_DONE : ST_IDLE;
				end else begin
					clr_row_d = clr_row_q + 1'b1;
				end
			end
			ST_IDLE: begin
				if (q_valid && !out_valid_q) begin
					q_pop    = 1'b1;
					rd_hit_d = 1'b0;
					state_d  = ST_DONE;
					case (q_cmd.op)
						ttcb_pkg::OP_PRINT: begin
							wr_en   = cur_in;
							wr_data = {ttcb_pkg::MAX_COLUMNS{q_cmd.ch}};
							col_d   = pr_col;
							row_d   = pr_row;
							tab_d   = '0;
							if (pr_scroll) begin
								sc_row_d = ttcb_pkg::NROW_W'(1);
								state_d  = ST_SCROLL;
							end
						end
						ttcb_pkg::OP_CR: begin
							col_d = '0;
						end
						ttcb_pkg::OP_LF: begin
							col_d = '0;
							row_d = lf_scroll ? last_row : ttcb_pkg::ROW_W'(row_inc);
							tab_d = '0;
							if (lf_scroll) begin
								sc_row_d = ttcb_pkg::NROW_W'(1);
								state_d  = ST_SCROLL;
							end
						end
						ttcb_pkg::OP_BS: begin
							if (col_q != '0) begin
								col_d   = col_dec;
								wr_en   = bs_in;
								wr_mask = dec_onehot;
							end
						end
						ttcb_pkg::OP_TAB: begin
							tab_d   = ttcb_pkg::TAB_CNT_W'(ttcb_pkg::TAB_STOP)
								- ttcb_pkg::TAB_CNT_W'(col_q[ttcb_pkg::TAB_LOW_W-1:0]);
							state_d = ST_TAB;
						end
						ttcb_pkg::OP_CLEAR: begin
							row_d     = '0;
							col_d     = '0;
							clr_row_d = '0;
							clr_op_d  = 1'b1;
							state_d   = ST_CLEAR;
						end
						ttcb_pkg::OP_READ: begin
							rd_en    = 1'b1;
							rd_row   = ttcb_pkg::ROW_W'(q_cmd.rr);
							rd_hit_d = (int'(q_cmd.rr) < int'(nr)) && (int'(q_cmd.rc) < int'(nc));
							rd_col_d = ttcb_pkg::COL_W'(q_cmd.rc);
						end
						default: begin
						end
					endcase
				end
			end
			ST_TAB: begin
				// one blank per cycle unless a scroll intervenes, each behaving as a printable byte
				wr_en = cur_in;
				col_d = pr_col;
				row_d = pr_row;
				tab_d = tab_cnt_q - 1'b1;
				if (pr_scroll) begin
					sc_row_d = ttcb_pkg::NROW_W'(1);
					state_d  = ST_SCROLL;
				end else if (tab_cnt_q == ttcb_pkg::TAB_CNT_W'(1)) begin
					state_d = ST_DONE;
				end
			end
			ST_SCROLL: begin
				// read row r while row r-2 takes row r-1, read the cycle before
				if (pend_q) begin
					wr_en   = 1'b1;
					wr_row  = pend_row_q - 1'b1;
					wr_mask = use_mask;
					wr_data = rd_data_q;
				end
				if (sc_row_q < nr) begin
					rd_en      = 1'b1;
					rd_row     = ttcb_pkg::ROW_W'(sc_row_q);
					pend_d     = 1'b1;
					pend_row_d = ttcb_pkg::ROW_W'(sc_row_q);
					sc_row_d   = sc_row_q + 1'b1;
				end else if (!pend_q) begin
					wr_en   = 1'b1;
					wr_row  = last_row;
					wr_mask = use_mask;
					state_d = (tab_cnt_q != '0) ? ST_TAB : ST_DONE;
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// cell store, one row wide with a byte mask on the write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int c = 0; c < ttcb_pkg::MAX_COLUMNS; c++) begin
				if (wr_mask[c]) cells_q[wr_row][c] <= wr_data[c];
			end
		end
		if (rd_en) rd_data_q <= cells_q[rd_row];
	end

	always_ff @(posedge clk) begin
		pend_row_q <= pend_row_d;
		rd_hit_q   <= rd_hit_d;
		rd_col_q   <= rd_col_d;
		sc_row_q   <= sc_row_d;
		tab_cnt_q  <= tab_d;
		if (state_q == ST_DONE) begin
			out_cell_q <= rd_hit_q ? rd_data_q[rd_col_q] : ttcb_pkg::BLANK;
			out_row_q  <= ttcb_pkg::OUT_ROW_W'(row_q);
			out_col_q  <= ttcb_pkg::OUT_COL_W'(col_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			row_q       <= '0;
			col_q       <= '0;
			clr_row_q   <= '0;
			clr_op_q    <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
			cols_q      <= ttcb_pkg::COLS_RESET;
			rows_q      <= ttcb_pkg::ROWS_RESET;
		end else begin
			state_q   <= state_d;
			row_q     <= row_d;
			col_q     <= col_d;
			clr_row_q <= clr_row_d;
			clr_op_q  <= clr_op_d;
			pend_q    <= pend_d;
			if (state_q == ST_DONE) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					ttcb_pkg::REG_COLUMNS: cols_q <= ttcb_pkg::CFG_COL_W'(cfg_data);
					ttcb_pkg::REG_ROWS:    rows_q <= ttcb_pkg::CFG_ROW_W'(cfg_data);
					default: begin
					end
				endcase
			end
		end
	end

	assign clearing   = (state_q == ST_CLEAR);
	assign out_valid  = out_valid_q;
	assign cell_char  = out_cell_q;
	assign cursor_row = out_row_q;
	assign cursor_col = out_col_q;

	a_pop_needs_free_out: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !out_valid_q)
		else $error("command taken while a result is still held");

	a_done_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |=> out_valid_q)
		else $error("finished command left no result");

	a_tab_count_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TAB) |-> (tab_cnt_q != '0))
		else $error("tab sequence running with no spaces left");

	a_cursor_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (col_q < ttcb_pkg::CUR_COL_W'(ttcb_pkg::MAX_COLUMNS)))
		else $error("cursor column beyond the store");

	a_scroll_dest_row: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SCROLL) && pend_q) |-> (pend_row_q != '0))
		else $error("scroll copy aimed above the first row");

endmodule

/* rtl/text_terminal_cell_buffer.sv */
// top level of the character-cell terminal screen buffer
// Input channel (in_valid/in_ready): one transfer carries action, byte_in, read_row and
// read_col. Action 0 puts a byte (printable, CR, LF, backspace/DEL, tab), action 1 blanks
// the screen and homes the cursor, action 2 reads one cell.
// Output channel (out_valid/out_ready): exactly one transfer per input transfer, in order,
// carrying cell_char (the cell read, else a space) and the cursor after the item.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 columns, 1 rows); the
// user must write only while the block is idle, which the block itself does not enforce.
// Out-of-range counts are clamped to 1..64 and 1..32, rows from the low 6 bits of cfg_data.
// Timing: each item passes through the command queue; the engine takes it only when idle
// with no result held. Put byte, CR, LF, backspace, read and ignored bytes go straight to
// the done state and a registered result. A tab writes its spaces in the tab state first;
// a line feed or wrap that scrolls adds a row-by-row copy of the rows in use through the
// single write port of the cell store; a clear blanks every store row in the clear state.
// The engine takes the next item only once the held result has left, never before.
// A two-entry command queue lets new items be taken while a result waits for the receiver.
// When out_ready is low the result is held and the engine stops after it; once the queue is
// full in_ready drops. Reset: a clearing pass (one screen row per cycle) blanks the store,
// with in_ready low throughout; the cursor starts at row 0, column 0.
module text_terminal_cell_buffer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [ttcb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ttcb_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [ttcb_pkg::ACTION_W-1:0]       action,
	input  logic [ttcb_pkg::BYTE_W-1:0]         byte_in,
	input  logic [ttcb_pkg::RROW_W-1:0]         read_row,
	input  logic [ttcb_pkg::RCOL_W-1:0]         read_col,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [ttcb_pkg::BYTE_W-1:0]         cell_char,
	output logic [ttcb_pkg::OUT_ROW_W-1:0]      cursor_row,
	output logic [ttcb_pkg::OUT_COL_W-1:0]      cursor_col
);

	logic           push, q_full, q_valid, q_pop, clearing;
	ttcb_pkg::cmd_t cmd, q_cmd;

	ttcb_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.action   (action),
		.byte_in  (byte_in),
		.read_row (read_row),
		.read_col (read_col),
		.q_full   (q_full),
		.clearing (clearing),
		.push     (push),
		.cmd      (cmd)
	);

	ttcb_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.cmd_in  (cmd),
		.full    (q_full),
		.pop     (q_pop),
		.q_valid (q_valid),
		.head    (q_cmd)
	);

	ttcb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.q_valid    (q_valid),
		.q_cmd      (q_cmd),
		.q_pop      (q_pop),
		.clearing   (clearing),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.cell_char  (cell_char),
		.cursor_row (cursor_row),
		.cursor_col (cursor_col)
	);

endmodule
